### rtl/elevator_request_scheduler_assert.svh
// Assertion macros for the elevator request scheduler.
`ifndef ELEVATOR_REQUEST_SCHEDULER_ASSERT_SVH
`define ELEVATOR_REQUEST_SCHEDULER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define ERS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ERS_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/ers_pkg.sv
// Types and constants shared by the elevator request scheduler modules.
package ers_pkg;

  localparam int FLOOR_W = 4;
  localparam int FLOORS  = 16;

  typedef enum logic [2:0] {
    EV_ACCEPT = 3'd0,
    EV_REJECT = 3'd1,
    EV_SELECT = 3'd2,
    EV_UP     = 3'd3,
    EV_DOWN   = 3'd4,
    EV_STOP   = 3'd5,
    EV_IDLE   = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    HEAD_IDLE = 2'd0,
    HEAD_UP   = 2'd1,
    HEAD_DOWN = 2'd2
  } heading_e;

  typedef enum logic [0:0] {
    REQ_ADD  = 1'b0,
    REQ_TICK = 1'b1
  } req_kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_STEP
  } state_e;

  typedef struct packed {
    logic               req_type;
    logic [FLOOR_W-1:0] floor;
    logic               direction;
  } req_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic [FLOOR_W-1:0] current_floor;
    logic [FLOOR_W-1:0] target_floor;
    logic [1:0]         heading;
    logic               moving;
  } res_t;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

endpackage

### rtl/ers_ctrl.sv
// Controller: sequences the capture and the execution step of each transfer.
module ers_ctrl import ers_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  output logic done_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.step;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_STEP;
        end
      end
      ST_STEP: begin
        busy_o     = 1'b1;
        cmd_o.step = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign done_o = done_q;

endmodule

### rtl/ers_datapath.sv
// Datapath: request bitmaps, car state, target selection and result register.
module ers_datapath import ers_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  req_t req_i,
  output res_t res_o
);

  function automatic logic [FLOORS-1:0] floor_mask(input logic [FLOOR_W-1:0] f);
    logic [FLOORS-1:0] m;
    for (int i = 0; i < FLOORS; i++) begin
      m[i] = (int'(f) == i);
    end
    return m;
  endfunction

  function automatic logic [FLOOR_W-1:0] lowest_set(input logic [FLOORS-1:0] m);
    logic [FLOOR_W-1:0] idx;
    idx = '0;
    for (int i = FLOORS - 1; i >= 0; i--) begin
      if (m[i]) idx = FLOOR_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [FLOOR_W-1:0] highest_set(input logic [FLOORS-1:0] m);
    logic [FLOOR_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < FLOORS; i++) begin
      if (m[i]) idx = FLOOR_W'(i);
    end
    return idx;
  endfunction

  req_t               req_q;
  res_t               res_q, res_d;
  logic [FLOOR_W-1:0] car_q, car_d;
  heading_e           heading_q, heading_d;
  logic               moving_q, moving_d;
  logic [FLOORS-1:0]  up_q, up_d;
  logic [FLOORS-1:0]  down_q, down_d;
  logic [FLOORS-1:0]  blocked_q, blocked_d;
  logic [FLOOR_W-1:0] goal_q, goal_d;
  logic               goal_act_q, goal_act_d;
  heading_e           forced_q, forced_d;
  logic               from_down_q, from_down_d;

  logic [FLOORS-1:0]  req_mask;
  logic [FLOORS-1:0]  goal_mask;
  logic               in_range;
  logic [FLOOR_W-1:0] up_lo, dn_hi;
  logic [FLOOR_W-1:0] up_gap, dn_gap;
  logic               pick_down;
  event_e             ev;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.step) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      car_q       <= '0;
      heading_q   <= HEAD_IDLE;
      moving_q    <= 1'b0;
      up_q        <= '0;
      down_q      <= '0;
      blocked_q   <= '0;
      goal_q      <= '0;
      goal_act_q  <= 1'b0;
      forced_q    <= HEAD_IDLE;
      from_down_q <= 1'b0;
    end else if (cmd_i.step) begin
      car_q       <= car_d;
      heading_q   <= heading_d;
      moving_q    <= moving_d;
      up_q        <= up_d;
      down_q      <= down_d;
      blocked_q   <= blocked_d;
      goal_q      <= goal_d;
      goal_act_q  <= goal_act_d;
      forced_q    <= forced_d;
      from_down_q <= from_down_d;
    end
  end

  assign req_mask  = floor_mask(req_q.floor);
  assign goal_mask = floor_mask(goal_q);
  assign in_range  = int'(req_q.floor) < FLOORS;
  assign up_lo     = lowest_set(up_q);
  assign dn_hi     = highest_set(down_q);
  assign up_gap    = (car_q > up_lo) ? car_q - up_lo : up_lo - car_q;
  assign dn_gap    = (car_q > dn_hi) ? car_q - dn_hi : dn_hi - car_q;

  always_comb begin
    car_d       = car_q;
    heading_d   = heading_q;
    moving_d    = moving_q;
    up_d        = up_q;
    down_d      = down_q;
    blocked_d   = blocked_q;
    goal_d      = goal_q;
    goal_act_d  = goal_act_q;
    forced_d    = forced_q;
    from_down_d = from_down_q;
    pick_down   = 1'b0;
    ev          = EV_IDLE;

    if (req_q.req_type == REQ_ADD) begin
      if (!in_range || (|(blocked_q & req_mask))) begin
        ev = EV_REJECT;
      end else begin
        blocked_d = blocked_q | req_mask;
        if (req_q.direction) down_d = down_q | req_mask;
        else                 up_d   = up_q | req_mask;
        ev = EV_ACCEPT;
      end
    end else if (goal_act_q) begin
      if (car_q < goal_q) begin
        car_d     = car_q + 1'b1;
        heading_d = HEAD_UP;
        moving_d  = 1'b1;
        ev        = EV_UP;
      end else if (car_q > goal_q) begin
        car_d     = car_q - 1'b1;
        heading_d = HEAD_DOWN;
        moving_d  = 1'b1;
        ev        = EV_DOWN;
      end else begin
        // Stop: free the floor and force the other set if ours ran dry.
        heading_d  = HEAD_IDLE;
        moving_d   = 1'b0;
        goal_act_d = 1'b0;
        blocked_d  = blocked_q & ~goal_mask;
        forced_d   = HEAD_IDLE;
        if (!from_down_q && (up_q == '0) && (down_q != '0)) forced_d = HEAD_DOWN;
        else if (from_down_q && (down_q == '0) && (up_q != '0)) forced_d = HEAD_UP;
        ev = EV_STOP;
      end
    end else if ((up_q == '0) && (down_q == '0)) begin
      ev = EV_IDLE;
    end else begin
      if (forced_q == HEAD_UP && (up_q != '0))          pick_down = 1'b0;
      else if (forced_q == HEAD_DOWN && (down_q != '0)) pick_down = 1'b1;
      else if (up_q == '0)                              pick_down = 1'b1;
      else if (down_q == '0)                            pick_down = 1'b0;
      else                                              pick_down = up_gap > dn_gap;
      if (pick_down) begin
        goal_d    = dn_hi;
        down_d    = down_q & ~floor_mask(dn_hi);
        heading_d = HEAD_DOWN;
      end else begin
        goal_d    = up_lo;
        up_d      = up_q & ~floor_mask(up_lo);
        heading_d = HEAD_UP;
      end
      from_down_d = pick_down;
      goal_act_d  = 1'b1;
      forced_d    = HEAD_IDLE;
      ev          = EV_SELECT;
    end

    res_d.event_res     = ev;
    res_d.current_floor = car_d;
    res_d.target_floor  = (goal_act_d || ev == EV_STOP) ? goal_d : '0;
    res_d.heading       = heading_d;
    res_d.moving        = moving_d;
  end

  assign res_o = res_q;

endmodule

### rtl/elevator_request_scheduler.sv
// Elevator request scheduler: add floor requests and step the car on ticks.
//
// Input channel: present req_i with start_i high; the transfer happens at a
// rising edge where start_i is high and busy_o is low. req_type selects an add
// request (floor, direction) or a tick that moves, selects or stops the car.
// Result channel: every transfer produces exactly one result on res_o, marked
// by done_o for a single cycle. The receiver cannot stall the block, so the
// result must be taken in that cycle.
// Sequence: the accepting edge captures the request in req_q; in the execute
// state the datapath computes the step, and the edge that ends it registers
// the result in res_q and raises done_o through done_q. busy_o is high only
// in the execute cycle, so no new request is taken while one is executing; a
// new start may arrive in the same cycle in which the previous result is shown.
// Target selection uses priority encoders over the FLOORS-wide up and down
// bitmaps, resolved within the single execute cycle.
// Reset: rst_ni clears the car to floor zero, idle, with empty request sets,
// no active target and no forced direction; no clearing pass is needed.
module elevator_request_scheduler import ers_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic done_o,
  output res_t res_o
);

  cmd_t cmd;

  ers_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  ers_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .res_o  (res_o)
  );

`include "elevator_request_scheduler_assert.svh"

  `ERS_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o, "no step after transfer")
  `ERS_ASSERT(a_accept_done, (start_i && !busy_o) |-> ##2 done_o, "result missing")
  `ERS_ASSERT(a_done_single, done_o |=> !done_o, "result strobe repeated")
  `ERS_ASSERT_NEVER(a_moving_idle, done_o && res_o.moving && res_o.heading == HEAD_IDLE,
    "car moving with idle heading")

endmodule

### tb/ers_checker.sv
// Checker for the elevator request scheduler: predicts each result and compares it.
module ers_checker import ers_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  req_t req_i,
  input  logic done_i,
  input  res_t res_i,
  output int   errors_o,
  output int   pending_o
);

  // Car and request state as the block should hold it.
  logic [FLOOR_W-1:0] car_floor_q;
  heading_e           car_heading_q;
  logic               car_moving_q;
  logic [FLOORS-1:0]  up_set_q;
  logic [FLOORS-1:0]  down_set_q;
  logic [FLOORS-1:0]  held_q;
  logic [FLOOR_W-1:0] goal_q;
  logic               goal_valid_q;
  logic               goal_down_q;
  heading_e           forced_q;

  res_t expected_q[$];
  int   mismatches;

  function automatic int lowest_floor(logic [FLOORS-1:0] set);
    for (int i = 0; i < FLOORS; i++)
      if (set[i]) return i;
    return 0;
  endfunction

  function automatic int highest_floor(logic [FLOORS-1:0] set);
    for (int i = FLOORS - 1; i >= 0; i--)
      if (set[i]) return i;
    return 0;
  endfunction

  function automatic int distance(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Apply one request to the car state and return the result it produces.
  task automatic serve_request(input req_t r, output res_t o);
    event_e ev;
    logic   pick_down;
    int     up_c;
    int     down_c;
    if (r.req_type == REQ_ADD) begin
      if (int'(r.floor) >= FLOORS || held_q[r.floor]) begin
        ev = EV_REJECT;
      end else begin
        held_q[r.floor] = 1'b1;
        if (r.direction) down_set_q[r.floor] = 1'b1;
        else up_set_q[r.floor] = 1'b1;
        ev = EV_ACCEPT;
      end
    end else if (goal_valid_q) begin
      if (car_floor_q < goal_q) begin
        car_floor_q++;
        car_heading_q = HEAD_UP;
        car_moving_q = 1'b1;
        ev = EV_UP;
      end else if (car_floor_q > goal_q) begin
        car_floor_q--;
        car_heading_q = HEAD_DOWN;
        car_moving_q = 1'b1;
        ev = EV_DOWN;
      end else begin
        car_heading_q = HEAD_IDLE;
        car_moving_q = 1'b0;
        goal_valid_q = 1'b0;
        held_q[goal_q] = 1'b0;
        forced_q = HEAD_IDLE;
        // Turn around when the set just served has run dry.
        if (!goal_down_q && up_set_q == '0 && down_set_q != '0) forced_q = HEAD_DOWN;
        else if (goal_down_q && down_set_q == '0 && up_set_q != '0) forced_q = HEAD_UP;
        ev = EV_STOP;
      end
    end else if (up_set_q == '0 && down_set_q == '0) begin
      ev = EV_IDLE;
    end else begin
      up_c = lowest_floor(up_set_q);
      down_c = highest_floor(down_set_q);
      if (forced_q == HEAD_UP && up_set_q != '0) pick_down = 1'b0;
      else if (forced_q == HEAD_DOWN && down_set_q != '0) pick_down = 1'b1;
      else if (up_set_q == '0) pick_down = 1'b1;
      else if (down_set_q == '0) pick_down = 1'b0;
      else pick_down = distance(int'(car_floor_q), up_c) >
                       distance(int'(car_floor_q), down_c);
      if (pick_down) begin
        goal_q = FLOOR_W'(down_c);
        down_set_q[down_c] = 1'b0;
        car_heading_q = HEAD_DOWN;
      end else begin
        goal_q = FLOOR_W'(up_c);
        up_set_q[up_c] = 1'b0;
        car_heading_q = HEAD_UP;
      end
      goal_down_q = pick_down;
      goal_valid_q = 1'b1;
      forced_q = HEAD_IDLE;
      ev = EV_SELECT;
    end
    o.event_res = ev;
    o.current_floor = car_floor_q;
    o.target_floor = (goal_valid_q || ev == EV_STOP) ? goal_q : '0;
    o.heading = car_heading_q;
    o.moving = car_moving_q;
  endtask

  task automatic note_mismatch(input string field, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    if (!rst_ni) begin
      car_floor_q   = '0;
      car_heading_q = HEAD_IDLE;
      car_moving_q  = 1'b0;
      up_set_q      = '0;
      down_set_q    = '0;
      held_q        = '0;
      goal_q        = '0;
      goal_valid_q  = 1'b0;
      goal_down_q   = 1'b0;
      forced_q      = HEAD_IDLE;
      expected_q.delete();
      mismatches    = 0;
      errors_o     <= 0;
      pending_o    <= 0;
    end else begin
      // Retire the oldest expectation before queuing a new transfer.
      if (done_i) begin
        got = res_i;
        if (expected_q.size() == 0) begin
          note_mismatch("unexpected result, event", -1, int'(got.event_res));
        end else begin
          want = expected_q.pop_front();
          if (got.event_res !== want.event_res)
            note_mismatch("event_res", int'(want.event_res), int'(got.event_res));
          if (got.current_floor !== want.current_floor)
            note_mismatch("current_floor", int'(want.current_floor),
                          int'(got.current_floor));
          if (got.target_floor !== want.target_floor)
            note_mismatch("target_floor", int'(want.target_floor), int'(got.target_floor));
          if (got.heading !== want.heading)
            note_mismatch("heading", int'(want.heading), int'(got.heading));
          if (got.moving !== want.moving)
            note_mismatch("moving", int'(want.moving), int'(got.moving));
        end
      end
      if (start_i && !busy_i) begin
        serve_request(req_i, want);
        expected_q.push_back(want);
      end
      errors_o  <= mismatches;
      pending_o <= expected_q.size();
    end
  end

endmodule

### tb/testbench.sv
// Top of the elevator request scheduler testbench: clock, reset, stimulus and verdict.
module testbench;
  import ers_pkg::*;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  req_t req_i   = '0;
  logic busy_o;
  logic done_o;
  res_t res_o;
  int   errors;
  int   pending;

  int max_gap;
  int add_pct;

  elevator_request_scheduler uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  ers_checker checker_i (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_i   (busy_o),
    .req_i    (req_i),
    .done_i   (done_o),
    .res_i    (res_o),
    .errors_o (errors),
    .pending_o(pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hold off a random number of cycles, then keep start up until the transfer.
  task automatic issue(input req_kind_e kind, input logic [FLOOR_W-1:0] fl, input logic dn);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= '{req_type: kind, floor: fl, direction: dn};
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic tick();
    issue(REQ_TICK, FLOOR_W'($urandom), 1'($urandom));
  endtask

  initial begin
    int lo;
    int hi;
    max_gap = 19;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle, duplicates, target at the car, forced turnaround.
    tick();
    issue(REQ_ADD, 4'd0, 1'b0);
    issue(REQ_ADD, 4'd0, 1'b1);
    tick();
    issue(REQ_ADD, 4'd0, 1'b0);
    tick();
    issue(REQ_ADD, 4'd15, 1'b1);
    issue(REQ_ADD, 4'd15, 1'b0);
    issue(REQ_ADD, 4'd2, 1'b0);
    tick();
    tick();
    tick();
    tick();
    issue(REQ_ADD, 4'd1, 1'b0);
    tick();
    issue(REQ_ADD, 4'd15, 1'b1);
    repeat (6) tick();
    issue(REQ_ADD, 4'd10, 1'b1);
    repeat (3) tick();

    // Random phases: vary idling and the mix of adds and ticks.
    for (int i = 0; i < 400; i++) begin
      if (i % 40 == 0) begin
        max_gap = ($urandom_range(0, 2) == 0) ? 0 : 19;
        add_pct = $urandom_range(20, 70);
        // Narrow the floor window now and then to provoke duplicates and ties.
        lo = $urandom_range(0, 1) ? 0 : $urandom_range(0, 10);
        hi = (lo == 0 && $urandom_range(0, 1)) ? FLOORS - 1 : lo + $urandom_range(1, 5);
      end
      if ($urandom_range(0, 99) < add_pct)
        issue(REQ_ADD, FLOOR_W'($urandom_range(lo, hi)), 1'($urandom));
      else
        tick();
    end
    start_i <= 1'b0;

    @(posedge clk_i);
    for (int n = 0; n < 1000 && pending != 0; n++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
